@@ design/bez_pkg.sv @@
package bez_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FILL,
    ST_OUT,
    ST_CLEAR
  } bez_state_e;

  // Input item kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_REBUILD = 1'b1;

  // Channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_CURVE_BLUE  = 2'd0;
  localparam logic [1:0] REG_CURVE_GREEN = 2'd1;
  localparam logic [1:0] REG_CURVE_RED   = 2'd2;

  // Multiplier schedule of one curve step
  localparam logic [3:0] STEP_UU     = 4'd0;
  localparam logic [3:0] STEP_VV     = 4'd1;
  localparam logic [3:0] STEP_W0     = 4'd2;
  localparam logic [3:0] STEP_W1     = 4'd3;
  localparam logic [3:0] STEP_W2     = 4'd4;
  localparam logic [3:0] STEP_W3     = 4'd5;
  localparam logic [3:0] STEP_PX0    = 4'd6;
  localparam logic [3:0] STEP_PY0    = 4'd10;
  localparam logic [3:0] STEP_LAST   = 4'd14;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned TBL_SIZE = 256;

endpackage

@@ design/bezier_tone_curve_lut.sv @@
// Channel   | Direction | Signals                                  | Handshake
// ----------+-----------+------------------------------------------+-------------------------
// command   | in        | kind_i channel_i pixel_{blue,green,red}_i | start_i && !busy_o
// result    | out       | out_{blue,green,red}_o build_done_o       | valid_o, one cycle
// config    | in        | cfg_index_i cfg_data_i                   | cfg_valid_i && cfg_ready_o
//
// A pixel transaction reads the three table memories at the accept edge, and the result
// follows in the next cycle. A rebuild runs, for each curve step i, the multiplier
// schedule on the shared multiplier and then fill writes on the table write port, over
// TABLE_DEPTH steps, then the result. After reset a clearing pass zeroes all three
// tables, one entry per cycle, with busy_o high.
// The receiver cannot stall: each result is shown for exactly one cycle with valid_o.
module bezier_tone_curve_lut #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_red_i,
  output logic        valid_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        build_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import bez_pkg::*;

  localparam int unsigned DEN   = TABLE_DEPTH - 1;
  localparam int unsigned IW    = $clog2(TABLE_DEPTH);
  localparam int unsigned RW    = $clog2(DEN + 1);
  localparam int unsigned U_INC = ONE_Q16 / DEN;
  localparam int unsigned R_INC = ONE_Q16 % DEN;

  // Configuration registers
  logic [63:0] curve_q [3];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q[0] <= '0;
      curve_q[1] <= '0;
      curve_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CURVE_BLUE:  curve_q[0] <= cfg_data_i;
        REG_CURVE_GREEN: curve_q[1] <= cfg_data_i;
        REG_CURVE_RED:   curve_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bez_state_e  state_q, state_d;
  logic [1:0]  ch_q, ch_d;
  logic        pix_q, pix_d;
  logic        done_q, done_d;
  logic [IW-1:0] i_q, i_d;
  logic [16:0] u_q, u_d;
  logic [RW-1:0] r_q, r_d;
  logic [3:0]  k_q, k_d;
  logic [33:0] uu_q, uu_d, vv_q, vv_d;
  logic [16:0] w_q [4];
  logic [16:0] w_d [4];
  logic [25:0] sx_q, sx_d, sy_q, sy_d;
  logic [7:0]  y_q, y_d, j_q, j_d;
  logic [52:0] prod_q;
  logic [35:0] mul_a;
  logic [16:0] mul_b;
  logic [16:0] v;
  logic [63:0] pts;
  logic [7:0]  top;
  logic        step_skip;
  logic        wr_en;
  logic        clr_en;
  logic [7:0]  wr_data;
  logic [RW:0] r_sum;
  logic [9:0]  x_raw, y_raw;
  logic [25:0] sy_fin;

  assign v   = 17'(ONE_Q16 - 32'(u_q));
  assign pts = (ch_q == CH_GREEN) ? curve_q[1] : (ch_q == CH_RED) ? curve_q[2] : curve_q[0];
  assign top = 8'(8'd255 - 8'(i_q));
  assign step_skip = (32'(i_q) > 32'd255) || (j_q > top);
  assign sy_fin = sy_q + 26'(prod_q);
  assign x_raw  = sx_q[25:16];
  assign y_raw  = sy_fin[25:16];

  // Select shared multiplier operands for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (k_q)
      STEP_UU: begin mul_a = 36'(u_q);  mul_b = u_q; end
      STEP_VV: begin mul_a = 36'(v);    mul_b = v;   end
      STEP_W0: begin mul_a = 36'(uu_q); mul_b = u_q; end
      STEP_W1: begin mul_a = {1'b0, uu_q, 1'b0} + 36'(uu_q); mul_b = v; end
      STEP_W2: begin mul_a = {1'b0, vv_q, 1'b0} + 36'(vv_q); mul_b = u_q; end
      STEP_W3: begin mul_a = 36'(vv_q); mul_b = v;   end
      default: begin
        if (k_q >= STEP_PY0) begin
          mul_a = 36'(w_q[2'(k_q - STEP_PY0)]);
          mul_b = 17'(pts[16*(k_q - STEP_PY0) + 8 +: 8]);
        end else begin
          mul_a = 36'(w_q[2'(k_q - STEP_PX0)]);
          mul_b = 17'(pts[16*(k_q - STEP_PX0) +: 8]);
        end
      end
    endcase
  end

  // Register the product before it is used
  always_ff @(posedge clk_i) begin
    prod_q <= 53'(mul_a) * 53'(mul_b);
  end

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    ch_d = ch_q; pix_d = pix_q; done_d = done_q;
    i_d = i_q; u_d = u_q; r_d = r_q; k_d = k_q;
    uu_d = uu_q; vv_d = vv_q; w_d = w_q;
    sx_d = sx_q; sy_d = sy_q; y_d = y_q; j_d = j_q;
    wr_en = 1'b0;
    r_sum = (RW+1)'(r_q) + (RW+1)'(R_INC);
    case (state_q)
      ST_CLEAR: begin
        // Zero one entry of every table per cycle
        j_d = j_q + 8'd1;
        if (j_q == 8'd255) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          ch_d = channel_i;
          pix_d = 1'b0;
          done_d = 1'b0;
          if (kind_i == KIND_PIXEL) begin
            pix_d = 1'b1;
            state_d = ST_OUT;
          end else if (channel_i == CH_BLUE || channel_i == CH_GREEN ||
                       channel_i == CH_RED) begin
            i_d = '0; u_d = '0; r_d = '0; k_d = STEP_UU;
            sx_d = '0; sy_d = '0;
            state_d = ST_MUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        // Consume the product of the previous step
        case (k_q)
          STEP_UU: ;
          STEP_VV: uu_d = prod_q[33:0];
          STEP_W0: vv_d = prod_q[33:0];
          STEP_W1: w_d[0] = prod_q[48:32];
          STEP_W2: w_d[1] = prod_q[48:32];
          STEP_W3: w_d[2] = prod_q[48:32];
          STEP_PX0: w_d[3] = prod_q[48:32];
          default: begin
            if (k_q > STEP_PY0) sy_d = sy_fin;
            else sx_d = sx_q + 26'(prod_q);
          end
        endcase
        k_d = k_q + 4'd1;
        if (k_q == STEP_LAST) begin
          y_d = (y_raw > 10'd255) ? 8'd255 : y_raw[7:0];
          j_d = (x_raw > 10'd255) ? 8'd255 : x_raw[7:0];
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!step_skip) wr_en = 1'b1;
        if (!step_skip && j_q != top) begin
          j_d = j_q + 8'd1;
        end else if (32'(i_q) == DEN) begin
          done_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          // Advance the curve parameter by 1/DEN in Q1.16
          i_d = i_q + IW'(1);
          if (r_sum >= (RW+1)'(DEN)) begin
            r_d = RW'(r_sum - (RW+1)'(DEN));
            u_d = u_q + 17'(U_INC + 1);
          end else begin
            r_d = RW'(r_sum);
            u_d = u_q + 17'(U_INC);
          end
          k_d = STEP_UU;
          sx_d = '0; sy_d = '0;
          state_d = ST_MUL;
        end
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ch_q <= '0; pix_q <= 1'b0; done_q <= 1'b0;
      i_q <= '0; k_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d; pix_q <= pix_d; done_q <= done_d;
      i_q <= i_d; k_q <= k_d; j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d; r_q <= r_d;
    uu_q <= uu_d; vv_q <= vv_d;
    w_q <= w_d;
    sx_q <= sx_d; sy_q <= sy_d;
    y_q <= y_d;
  end

  // Table memories: one write port for rebuilds and clearing, one registered read for pixels
  logic [7:0] mem_b [TBL_SIZE];
  logic [7:0] mem_g [TBL_SIZE];
  logic [7:0] mem_r [TBL_SIZE];
  logic [7:0] rd_b_q, rd_g_q, rd_r_q;

  assign clr_en  = (state_q == ST_CLEAR);
  assign wr_data = clr_en ? 8'd0 : y_q;

  always_ff @(posedge clk_i) begin
    if (clr_en || (wr_en && ch_q == CH_BLUE))  mem_b[j_q] <= wr_data;
    if (clr_en || (wr_en && ch_q == CH_GREEN)) mem_g[j_q] <= wr_data;
    if (clr_en || (wr_en && ch_q == CH_RED))   mem_r[j_q] <= wr_data;
    rd_b_q <= mem_b[pixel_blue_i];
    rd_g_q <= mem_g[pixel_green_i];
    rd_r_q <= mem_r[pixel_red_i];
  end

  // Drive the result for one cycle
  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = (state_q == ST_OUT);
  assign out_blue_o   = pix_q ? rd_b_q : 8'd0;
  assign out_green_o  = pix_q ? rd_g_q : 8'd0;
  assign out_red_o    = pix_q ? rd_r_q : 8'd0;
  assign build_done_o = done_q;

endmodule
